>>> rtl/core/phcr_pkg.sv
// ----------------------------------------------------------------------------
// phcr_pkg
// Shared types and constants for the pedal hysteresis change reporter.
// ----------------------------------------------------------------------------
package phcr_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int SAMPLE_W     = 8;
  localparam int CHANNEL_W    = 2;
  localparam int POSITION_W   = 7;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_HYST_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_ENABLE  = 1'd1;

  localparam logic [SAMPLE_W-1:0] HYST_THRESHOLD_RESET = 8'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic [CHANNEL_W-1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]  out_channel;
    logic [POSITION_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic                  going_up;
    logic [SAMPLE_W-1:0]   held_level;
    logic [POSITION_W-1:0] reported_position;
  } chan_state_t;

  typedef struct packed {
    chan_state_t           next_state;
    logic                  changed;
    logic [POSITION_W-1:0] position;
  } track_result_t;

endpackage

>>> rtl/core/phcr_track.sv
// ----------------------------------------------------------------------------
// phcr_track
// Hysteresis tracking and change detection for one channel's state.
// ----------------------------------------------------------------------------
module phcr_track
  import phcr_pkg::*;
(
  input  chan_state_t          cur,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [SAMPLE_W-1:0]  threshold,
  output track_result_t        result
);

  logic [SAMPLE_W:0]     held_plus_thr;
  logic [SAMPLE_W:0]     sample_plus_thr;
  logic                  going_up_next;
  logic [SAMPLE_W-1:0]   held_next;
  logic [POSITION_W-1:0] pos;

  assign held_plus_thr   = {1'b0, cur.held_level} + {1'b0, threshold};
  assign sample_plus_thr = {1'b0, sample} + {1'b0, threshold};

  always_comb begin
    going_up_next = cur.going_up;
    held_next     = cur.held_level;
    if (!cur.going_up) begin
      if ({1'b0, sample} > held_plus_thr) begin
        going_up_next = 1'b1;
        held_next     = sample;
      end else if (sample < cur.held_level) begin
        held_next = sample;
      end
    end else begin
      // sample < held - thr, kept unsigned
      if (sample_plus_thr < {1'b0, cur.held_level}) begin
        going_up_next = 1'b0;
        held_next     = sample;
      end else if (sample >= cur.held_level) begin
        held_next = sample;
      end
    end
  end

  assign pos = held_next[SAMPLE_W-1:1];

  assign result.next_state.going_up          = going_up_next;
  assign result.next_state.held_level        = held_next;
  assign result.next_state.reported_position = pos;
  assign result.changed                      = (pos != cur.reported_position);
  assign result.position                     = pos;

endmodule

>>> rtl/core/phcr_state.sv
// ----------------------------------------------------------------------------
// phcr_state
// Per-channel state registers with channel read select and write enable.
// ----------------------------------------------------------------------------
module phcr_state
  import phcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [CHANNEL_W-1:0] channel,
  input  chan_state_t          wdata,
  output chan_state_t          rdata
);

  chan_state_t state [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (rst) begin
        state[i] <= '0;
      end else if (we && (channel == CHANNEL_W'(i))) begin
        state[i] <= wdata;
      end
    end
  end

  always_comb begin
    rdata = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (channel == CHANNEL_W'(i)) begin
        rdata = state[i];
      end
    end
  end

endmodule

>>> rtl/core/pedal_hysteresis_change_report.sv
// ----------------------------------------------------------------------------
// pedal_hysteresis_change_report
// Per-channel directional hysteresis on pedal samples, reporting changes
// of the 7-bit position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): one sample with its
//   channel number per item. The item lands in an input register and is
//   tracked against that channel's state as it leaves that register.
//   Output channel (out_valid / out_stall / out_item): at most one item per
//   input, carrying the channel and its new position, only when reporting
//   is enabled and the position differs from the last one reported.
//   Items for a channel number at or above NUM_CHANNELS are dropped.
//   Result path: the input register, then the output register.
//   Throughput: one item per cycle while no pending result is stalled; the
//   tracking step reads and writes the selected channel's state in the same cycle.
//   When out_stall holds a pending result, the input register holds too and
//   in_stall rises once it is full.
//   Config (cfg_we / cfg_index / cfg_data): write while idle only.
//   Reset: all channels going down at level 0 with position 0, threshold 1,
//   reporting disabled, both pipeline registers empty.
// ----------------------------------------------------------------------------
module pedal_hysteresis_change_report
  import phcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [SAMPLE_W-1:0] hyst_threshold;
  logic                report_enable;

  logic          s1_valid;
  in_item_t      s1_item;
  logic          advance;
  logic          ch_ok;
  logic          process;
  logic          emit;
  logic          out_valid_next;
  chan_state_t   cur_state;
  track_result_t trk;

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_threshold <= HYST_THRESHOLD_RESET;
      report_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HYST_THRESHOLD: hyst_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_REPORT_ENABLE:  report_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  assign ch_ok   = ({1'b0, s1_item.channel} < (CHANNEL_W + 1)'(NUM_CHANNELS));
  assign process = advance && report_enable && ch_ok;
  assign emit    = process && trk.changed;

  phcr_state u_state (
    .clk     (clk),
    .rst     (rst),
    .we      (process),
    .channel (s1_item.channel),
    .wdata   (trk.next_state),
    .rdata   (cur_state)
  );

  phcr_track u_track (
    .cur       (cur_state),
    .sample    (s1_item.sample),
    .threshold (hyst_threshold),
    .result    (trk)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_channel <= s1_item.channel;
      out_item.position    <= trk.position;
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input register advanced over a blocked result");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted result not presented");

  a_no_emit_disabled: assert property (@(posedge clk) disable iff (rst)
    emit |-> report_enable && ch_ok)
    else $error("result emitted while disabled or for a bad channel");

  a_out_channel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_item.out_channel} < (CHANNEL_W + 1)'(NUM_CHANNELS)))
    else $error("result channel out of range");

  a_empty_never_stalls: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input register");

endmodule
